/* rtl/core/buffer_slot_allocator_defines.svh */
// Assertion macros for the slot allocator; they expect clk and rst_n in scope.
`ifndef BUFFER_SLOT_ALLOCATOR_DEFINES_SVH
`define BUFFER_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bsa_pkg.sv */
package bsa_pkg;

    localparam int MAX_IDX_W = 8;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_UNLOCK = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_LOCKED   = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TGT_RD,
        S_TGT_WR
    } ctrl_state_t;

    typedef struct packed {
        logic                 rd_en;
        logic [MAX_IDX_W-1:0] rd_addr;
        logic                 wr_en;
        logic [MAX_IDX_W-1:0] wr_addr;
        slot_state_t          wr_data;
    } mem_req_t;

endpackage

/* rtl/core/bsa_slot_mem.sv */
module bsa_slot_mem #(
    parameter int SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsa_pkg::mem_req_t     req,
    output bsa_pkg::slot_state_t  rd_data
);
    import bsa_pkg::*;

    localparam int IDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;

    slot_state_t mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    slot_state_t rd_raw_reg;
    logic rd_valid_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    assign rd_addr = req.rd_addr[IDX_W-1:0];
    assign wr_addr = req.wr_addr[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    // never-written entries read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : ST_EMPTY;

endmodule

/* rtl/core/bsa_ctrl.sv */
`include "buffer_slot_allocator_defines.svh"

module bsa_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            opcode,
    input  logic [3:0]            target_slot,
    output logic                  busy,
    output logic                  done,
    output logic [3:0]            found_slot,
    output logic                  write_back,
    output logic                  all_locked,
    output bsa_pkg::mem_req_t     mem_req,
    input  bsa_pkg::slot_state_t  rd_data
);
    import bsa_pkg::*;

    localparam int IDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS - 1);

    ctrl_state_t state_reg, state_next;
    logic             phase_rr_reg, phase_rr_next;
    logic             is_free_reg, is_free_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_addr_reg, chk_addr_next;
    logic             chk_last_reg, chk_last_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] rr_reg, rr_next;
    logic             done_reg, done_next;
    logic [3:0]       found_slot_reg, found_slot_next;
    logic             write_back_reg, write_back_next;
    logic             all_locked_reg, all_locked_next;

    logic             accept;
    logic             tgt_ok;
    logic             issue;
    logic             hit;
    logic             scan_end;
    logic [IDX_W-1:0] addr_inc;
    logic [IDX_W-1:0] rr_inc;

    assign accept   = start && (state_reg == S_IDLE);
    assign tgt_ok   = (32'(target_slot) < SLOTS);
    assign issue    = (cnt_reg < FULL_CNT);
    assign hit      = chk_valid_reg &&
                      (phase_rr_reg ? (rd_data == ST_OCCUPIED) : (rd_data == ST_EMPTY));
    assign scan_end = chk_valid_reg && chk_last_reg && !hit;
    assign addr_inc = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
    assign rr_inc   = (rr_reg == LAST_IDX) ? '0 : rr_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_FIND)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (((opcode == OP_UNLOCK) || (opcode == OP_FREE)) && tgt_ok)
                    begin
                        state_next = S_TGT_RD;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit || (scan_end && phase_rr_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            S_TGT_RD: state_next = S_TGT_WR;
            S_TGT_WR: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        phase_rr_next   = phase_rr_reg;
        is_free_next    = is_free_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        chk_valid_next  = 1'b0;
        chk_addr_next   = chk_addr_reg;
        chk_last_next   = chk_last_reg;
        used_next       = used_reg;
        rr_next         = rr_reg;
        done_next       = 1'b0;
        found_slot_next = found_slot_reg;
        write_back_next = write_back_reg;
        all_locked_next = all_locked_reg;
        mem_req         = '0;
        mem_req.wr_data = ST_EMPTY;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_FIND)
                    begin
                        cnt_next = '0;
                        if (used_reg == FULL_CNT)
                        begin
                            phase_rr_next = 1'b1;
                            addr_next     = rr_reg;
                            rr_next       = rr_inc;
                        end
                        else
                        begin
                            phase_rr_next = 1'b0;
                            addr_next     = '0;
                        end
                    end
                    else if (((opcode == OP_UNLOCK) || (opcode == OP_FREE)) && tgt_ok)
                    begin
                        addr_next    = IDX_W'(target_slot);
                        is_free_next = (opcode == OP_FREE);
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        found_slot_next = 4'd0;
                        write_back_next = 1'b0;
                        all_locked_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                // read one slot per cycle, check it the cycle after
                mem_req.rd_en   = issue;
                mem_req.rd_addr = MAX_IDX_W'(addr_reg);
                if (issue)
                begin
                    addr_next      = addr_inc;
                    cnt_next       = cnt_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = addr_reg;
                    chk_last_next  = (cnt_reg == LAST_CNT);
                end
                if (hit)
                begin
                    chk_valid_next  = 1'b0;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = MAX_IDX_W'(chk_addr_reg);
                    mem_req.wr_data = ST_LOCKED;
                    if (!phase_rr_reg)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                    done_next       = 1'b1;
                    found_slot_next = 4'(chk_addr_reg);
                    write_back_next = phase_rr_reg;
                    all_locked_next = 1'b0;
                end
                else if (scan_end)
                begin
                    chk_valid_next = 1'b0;
                    if (!phase_rr_reg)
                    begin
                        phase_rr_next = 1'b1;
                        addr_next     = rr_reg;
                        rr_next       = rr_inc;
                        cnt_next      = '0;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        found_slot_next = 4'd0;
                        write_back_next = 1'b0;
                        all_locked_next = 1'b1;
                    end
                end
            end
            S_TGT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = MAX_IDX_W'(addr_reg);
            end
            S_TGT_WR:
            begin
                mem_req.wr_addr = MAX_IDX_W'(addr_reg);
                if (is_free_reg)
                begin
                    if (rd_data != ST_EMPTY)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = ST_EMPTY;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - 1'b1;
                        end
                    end
                end
                else if (rd_data == ST_LOCKED)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = ST_OCCUPIED;
                end
                done_next       = 1'b1;
                found_slot_next = 4'd0;
                write_back_next = 1'b0;
                all_locked_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            used_reg      <= '0;
            rr_reg        <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            used_reg      <= used_next;
            rr_reg        <= rr_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_rr_reg   <= phase_rr_next;
        is_free_reg    <= is_free_next;
        addr_reg       <= addr_next;
        cnt_reg        <= cnt_next;
        chk_addr_reg   <= chk_addr_next;
        chk_last_reg   <= chk_last_next;
        found_slot_reg <= found_slot_next;
        write_back_reg <= write_back_next;
        all_locked_reg <= all_locked_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign found_slot = found_slot_reg;
    assign write_back = write_back_reg;
    assign all_locked = all_locked_reg;

    `BSA_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE, "strobe while busy")
    `BSA_ASSERT_IMP(a_fail_clean, done_reg && all_locked_reg,
        !write_back_reg && (found_slot_reg == 4'd0), "failed find carries a slot")
    `BSA_ASSERT_IMP(a_used_range, 1'b1, used_reg <= FULL_CNT, "used count overflow")
    `BSA_ASSERT_NXT(a_accept_resp, start && !busy, busy || done_reg, "word dropped")
    `BSA_ASSERT_IMP(a_wr_state, mem_req.wr_en,
        (state_reg == S_SCAN) || (state_reg == S_TGT_WR), "stray slot write")

endmodule

/* rtl/core/buffer_slot_allocator.sv */
// Channel   Handshake             Word
// request   start / busy          opcode, target_slot
// result    done (one cycle)      found_slot, write_back, all_locked
//
// Find: slot memory is scanned one entry per cycle, checked in the next cycle;
// a free-slot scan runs first unless all slots are used, and a round-robin scan
// follows if it runs dry. Unlock/free: read-modify-write of the target slot;
// an unused opcode or an out-of-range target strobes done without any action.
// Reset: all slots empty, count and pointer zero; no clearing pass needed.
// busy drops in the strobe cycle; the receiver cannot stall the result.
module buffer_slot_allocator #(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [3:0] target_slot,
    output logic       done,
    output logic [3:0] found_slot,
    output logic       write_back,
    output logic       all_locked
);
    import bsa_pkg::*;

    mem_req_t    mem_req;
    slot_state_t rd_data;

    bsa_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .target_slot(target_slot),
        .busy       (busy),
        .done       (done),
        .found_slot (found_slot),
        .write_back (write_back),
        .all_locked (all_locked),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    bsa_slot_mem #(
        .SLOTS(SLOTS)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rd_data(rd_data)
    );

endmodule
